// ===== hdl/bdti_pkg.sv =====
// Shared constants, codes and types of the binned decision tree inference block.
// Depends on nothing; every other file refers to it by scoped names.
package bdti_pkg;

   localparam int MAX_LEAVES   = 64;
   localparam int MAX_FEATURES = 256;
   localparam int BIN_BITS     = 16;

   localparam int NODE_DEPTH = MAX_LEAVES - 1;
   localparam int LEAF_AW    = $clog2(MAX_LEAVES);
   localparam int FEAT_AW    = $clog2(MAX_FEATURES);
   localparam int COUNT_W    = 7;
   localparam int CHILD_W    = 6;
   localparam int FEATURE_W  = 8;
   localparam int LENGTH_W   = 9;
   localparam int VALUE_W    = 32;

   typedef enum logic [1:0] {
      OP_WRITE_NODE = 2'd0,
      OP_WRITE_LEAF = 2'd1,
      OP_WRITE_BIN  = 2'd2,
      OP_PREDICT    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NODE,
      ST_BIN,
      ST_LEAF
   } state_type;

   typedef struct packed {
      logic               is_leaf;
      logic [CHILD_W-1:0] idx;
   } child_type;

   typedef struct packed {
      logic [FEATURE_W-1:0] feature;
      logic [BIN_BITS-1:0]  split;
      child_type            left;
      child_type            right;
   } node_type;

   localparam node_type NODE_RESET = '{
      feature: '0,
      split:   '1,
      left:    '{is_leaf: 1'b1, idx: '0},
      right:   '{is_leaf: 1'b1, idx: '0}
   };

   typedef struct packed {
      logic               rd_en;
      logic [LEAF_AW-1:0] rd_addr;
      logic               node_we;
      logic               leaf_we;
      logic [LEAF_AW-1:0] wr_addr;
      node_type           node;
      logic [VALUE_W-1:0] leaf_value;
   } tree_cmd_type;

   typedef struct packed {
      logic                rd_en;
      logic [FEAT_AW-1:0]  rd_addr;
      logic                we;
      logic [FEAT_AW-1:0]  wr_addr;
      logic [BIN_BITS-1:0] wr_bin;
   } sample_cmd_type;

endpackage

// ===== hdl/bdti_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
// Depends on bdti_pkg for field widths.
interface bdti_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          op;
   logic [7:0]                          index;
   logic [bdti_pkg::FEATURE_W-1:0]      split_feature;
   logic [15:0]                         split_bin;
   logic                                left_is_leaf;
   logic [bdti_pkg::CHILD_W-1:0]        left_index;
   logic                                right_is_leaf;
   logic [bdti_pkg::CHILD_W-1:0]        right_index;
   logic signed [bdti_pkg::VALUE_W-1:0] leaf_value;
   logic [15:0]                         feature_bin;
   logic [bdti_pkg::LENGTH_W-1:0]       sample_length;

   modport source (
      output valid, op, index, split_feature, split_bin, left_is_leaf, left_index,
             right_is_leaf, right_index, leaf_value, feature_bin, sample_length,
      input  ready
   );
   modport sink (
      input  valid, op, index, split_feature, split_bin, left_is_leaf, left_index,
             right_is_leaf, right_index, leaf_value, feature_bin, sample_length,
      output ready
   );
endinterface

interface bdti_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bdti_pkg::CHILD_W-1:0]        leaf_number;
   logic signed [bdti_pkg::VALUE_W-1:0] prediction;
   logic                                leaf_reached;

   modport source (
      output valid, leaf_number, prediction, leaf_reached,
      input  ready
   );
   modport sink (
      input  valid, leaf_number, prediction, leaf_reached,
      output ready
   );
endinterface

// ===== hdl/bdti_tree_mem.sv =====
// Tree memory: one entry per index holds an internal node and a leaf value.
// Node 0 and the leaf values read as their reset contents until written.
// Depends on bdti_pkg.
module bdti_tree_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  bdti_pkg::tree_cmd_type        cmd,
   output bdti_pkg::node_type            node_rd,
   output logic [bdti_pkg::VALUE_W-1:0]  leaf_rd
);

   typedef struct packed {
      bdti_pkg::node_type               node;
      logic [bdti_pkg::VALUE_W-1:0]     leaf;
   } entry_type;

   entry_type                          mem [bdti_pkg::MAX_LEAVES];
   entry_type                          rd_ff;
   logic                               node0_ok_ff;
   logic                               node0_ok_in;
   logic [bdti_pkg::MAX_LEAVES-1:0]    leaf_ok_ff;
   logic [bdti_pkg::MAX_LEAVES-1:0]    leaf_ok_in;
   logic                               node_dflt_ff;
   logic                               leaf_ok_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.node_we) begin
         mem[cmd.wr_addr].node <= cmd.node;
      end
      if (cmd.leaf_we) begin
         mem[cmd.wr_addr].leaf <= cmd.leaf_value;
      end
      if (cmd.rd_en) begin
         rd_ff         <= mem[cmd.rd_addr];
         node_dflt_ff  <= (cmd.rd_addr == '0) && !node0_ok_ff;
         leaf_ok_rd_ff <= leaf_ok_ff[cmd.rd_addr];
      end
   end

   always_comb begin
      node0_ok_in = node0_ok_ff;
      leaf_ok_in  = leaf_ok_ff;
      if (cmd.node_we && (cmd.wr_addr == '0)) begin
         node0_ok_in = 1'b1;
      end
      if (cmd.leaf_we) begin
         leaf_ok_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node0_ok_ff <= 1'b0;
         leaf_ok_ff  <= '0;
      end else begin
         node0_ok_ff <= node0_ok_in;
         leaf_ok_ff  <= leaf_ok_in;
      end
   end

   assign node_rd = node_dflt_ff ? bdti_pkg::NODE_RESET : rd_ff.node;
   assign leaf_rd = leaf_ok_rd_ff ? rd_ff.leaf : '0;

endmodule

// ===== hdl/bdti_sample_mem.sv =====
// Sample memory: feature bins of the current sample, one read port, one write port.
// Contents are undefined until written. Depends on bdti_pkg.
module bdti_sample_mem (
   input  logic                           clock,
   input  bdti_pkg::sample_cmd_type       cmd,
   output logic [bdti_pkg::BIN_BITS-1:0]  bin_rd
);

   logic [bdti_pkg::BIN_BITS-1:0] mem [bdti_pkg::MAX_FEATURES];
   logic [bdti_pkg::BIN_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.wr_addr] <= cmd.wr_bin;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   assign bin_rd = rd_ff;

endmodule

// ===== hdl/bdti_walker.sv =====
// Request decoder and tree walk sequencer with the response register.
// Drives the tree and sample memories. Depends on bdti_pkg and bdti_if.
module bdti_walker (
   input  logic                              clock,
   input  logic                              reset,
   bdti_req_if.sink                          req_if,
   bdti_rsp_if.source                        rsp_if,
   input  logic [bdti_pkg::COUNT_W-1:0]      leaf_count,
   output bdti_pkg::tree_cmd_type            tree_cmd,
   input  bdti_pkg::node_type                node_rd,
   input  logic [bdti_pkg::VALUE_W-1:0]      leaf_rd,
   output bdti_pkg::sample_cmd_type          sample_cmd,
   input  logic [bdti_pkg::BIN_BITS-1:0]     bin_rd
);

   bdti_pkg::state_type                state_ff, state_in;
   logic [bdti_pkg::LENGTH_W-1:0]      length_ff, length_in;
   logic [bdti_pkg::COUNT_W-1:0]       bound_ff, bound_in;
   logic [bdti_pkg::COUNT_W-1:0]       step_ff, step_in;
   logic                               present_ff, present_in;
   logic [bdti_pkg::CHILD_W-1:0]       res_leaf_ff, res_leaf_in;
   logic                               res_reached_ff, res_reached_in;
   logic                               res_zero_ff, res_zero_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bdti_pkg::CHILD_W-1:0]       rsp_leaf_ff, rsp_leaf_in;
   logic [bdti_pkg::VALUE_W-1:0]       rsp_pred_ff, rsp_pred_in;
   logic                               rsp_reached_ff, rsp_reached_in;

   bdti_pkg::op_type                   op;
   logic                               accept;
   logic                               out_free;
   logic [bdti_pkg::COUNT_W-1:0]       bound_new;
   logic [bdti_pkg::BIN_BITS-1:0]      bin_val;
   bdti_pkg::child_type                child;
   logic [bdti_pkg::COUNT_W-1:0]       step_next;
   logic                               leaf_in_range;
   logic                               node_in_range;
   logic                               exhausted;
   logic                               walk_done;

   assign op            = bdti_pkg::op_type'(req_if.op);
   assign req_if.ready  = (state_ff == bdti_pkg::ST_IDLE);
   assign accept        = req_if.valid && req_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign bound_new     = (int'(leaf_count) > bdti_pkg::MAX_LEAVES) ?
                          bdti_pkg::COUNT_W'(bdti_pkg::MAX_LEAVES) : leaf_count;
   assign bin_val       = present_ff ? bin_rd : '0;
   assign child         = (bin_val <= node_rd.split) ? node_rd.left : node_rd.right;
   assign step_next     = step_ff + bdti_pkg::COUNT_W'(1);
   assign leaf_in_range = int'(child.idx) < int'(bound_ff);
   assign node_in_range = int'(child.idx) < bdti_pkg::NODE_DEPTH;
   assign exhausted     = (step_next == bound_ff);
   assign walk_done     = child.is_leaf || !node_in_range || exhausted;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdti_pkg::ST_IDLE: begin
            if (accept && (op == bdti_pkg::OP_PREDICT)) begin
               state_in = (bound_new == '0) ? bdti_pkg::ST_LEAF : bdti_pkg::ST_NODE;
            end
         end
         bdti_pkg::ST_NODE: begin
            state_in = bdti_pkg::ST_BIN;
         end
         bdti_pkg::ST_BIN: begin
            state_in = walk_done ? bdti_pkg::ST_LEAF : bdti_pkg::ST_NODE;
         end
         bdti_pkg::ST_LEAF: begin
            if (out_free) begin
               state_in = bdti_pkg::ST_IDLE;
            end
         end
         default: state_in = bdti_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      tree_cmd        = '0;
      sample_cmd      = '0;
      length_in       = length_ff;
      bound_in        = bound_ff;
      step_in         = step_ff;
      present_in      = present_ff;
      res_leaf_in     = res_leaf_ff;
      res_reached_in  = res_reached_ff;
      res_zero_in     = res_zero_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_leaf_in     = rsp_leaf_ff;
      rsp_pred_in     = rsp_pred_ff;
      rsp_reached_in  = rsp_reached_ff;

      tree_cmd.wr_addr         = req_if.index[bdti_pkg::LEAF_AW-1:0];
      tree_cmd.node.feature    = req_if.split_feature;
      tree_cmd.node.split      = req_if.split_bin[bdti_pkg::BIN_BITS-1:0];
      tree_cmd.node.left       = '{is_leaf: req_if.left_is_leaf, idx: req_if.left_index};
      tree_cmd.node.right      = '{is_leaf: req_if.right_is_leaf, idx: req_if.right_index};
      tree_cmd.leaf_value      = req_if.leaf_value;
      sample_cmd.wr_addr       = req_if.index[bdti_pkg::FEAT_AW-1:0];
      sample_cmd.wr_bin        = req_if.feature_bin[bdti_pkg::BIN_BITS-1:0];

      unique case (state_ff)
         bdti_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  bdti_pkg::OP_WRITE_NODE: begin
                     tree_cmd.node_we = int'(req_if.index) < bdti_pkg::NODE_DEPTH;
                  end
                  bdti_pkg::OP_WRITE_LEAF: begin
                     tree_cmd.leaf_we = (int'(req_if.index) < int'(leaf_count)) &&
                                        (int'(req_if.index) < bdti_pkg::MAX_LEAVES);
                  end
                  bdti_pkg::OP_WRITE_BIN: begin
                     sample_cmd.we = int'(req_if.index) < bdti_pkg::MAX_FEATURES;
                  end
                  bdti_pkg::OP_PREDICT: begin
                     length_in      = req_if.sample_length;
                     bound_in       = bound_new;
                     step_in        = '0;
                     res_leaf_in    = '0;
                     res_reached_in = 1'b0;
                     res_zero_in    = (bound_new == '0);
                     tree_cmd.rd_en   = (bound_new != '0);
                     tree_cmd.rd_addr = '0;
                  end
                  default: ;
               endcase
            end
         end
         bdti_pkg::ST_NODE: begin
            sample_cmd.rd_en   = 1'b1;
            sample_cmd.rd_addr = node_rd.feature[bdti_pkg::FEAT_AW-1:0];
            present_in = (int'(node_rd.feature) < int'(length_ff)) &&
                         (int'(node_rd.feature) < bdti_pkg::MAX_FEATURES);
         end
         bdti_pkg::ST_BIN: begin
            tree_cmd.rd_addr = bdti_pkg::LEAF_AW'(child.idx);
            if (child.is_leaf) begin
               tree_cmd.rd_en = leaf_in_range;
               res_leaf_in    = leaf_in_range ? child.idx : '0;
               res_reached_in = leaf_in_range;
               res_zero_in    = !leaf_in_range;
            end else if (!node_in_range) begin
               res_leaf_in    = '0;
               res_reached_in = 1'b0;
               res_zero_in    = 1'b1;
            end else if (exhausted) begin
               tree_cmd.rd_en   = 1'b1;
               tree_cmd.rd_addr = '0;
               res_leaf_in      = '0;
               res_reached_in   = 1'b0;
               res_zero_in      = 1'b0;
            end else begin
               tree_cmd.rd_en = 1'b1;
               step_in        = step_next;
            end
         end
         bdti_pkg::ST_LEAF: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_leaf_in    = res_leaf_ff;
               rsp_pred_in    = res_zero_ff ? '0 : leaf_rd;
               rsp_reached_in = res_reached_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdti_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      length_ff      <= length_in;
      bound_ff       <= bound_in;
      step_ff        <= step_in;
      present_ff     <= present_in;
      res_leaf_ff    <= res_leaf_in;
      res_reached_ff <= res_reached_in;
      res_zero_ff    <= res_zero_in;
      rsp_leaf_ff    <= rsp_leaf_in;
      rsp_pred_ff    <= rsp_pred_in;
      rsp_reached_ff <= rsp_reached_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.leaf_number  = rsp_leaf_ff;
   assign rsp_if.prediction   = rsp_pred_ff;
   assign rsp_if.leaf_reached = rsp_reached_ff;

endmodule

// ===== hdl/binned_decision_tree_inference.sv =====
// Top level of the binned decision tree inference block: leaf count register,
// walk sequencer, tree memory and sample memory. Depends on bdti_pkg and bdti_if.
//
//   channel   direction  handshake          carries
//   req_if    in         valid/ready        write node, write leaf, write bin, predict
//   rsp_if    out        valid/ready        leaf_number, prediction, leaf_reached
//   csr_*     in         csr_we, no wait    leaf_count (7 bits)
//
// Writes complete without leaving idle. A predict reads the tree memory and then
// the sample memory for each node visited, at most min(leaf_count, 64) nodes, then
// reads the leaf and loads the response; an empty tree skips the walk, predicts zero.
// Reset is synchronous, active high; no clearing pass is needed.
// A pending response stalls only the end of the next predict; writes still pass.
module binned_decision_tree_inference (
   input  logic                          clock,
   input  logic                          reset,
   bdti_req_if.sink                      req_if,
   bdti_rsp_if.source                    rsp_if,
   input  logic                          csr_we,
   input  logic [bdti_pkg::COUNT_W-1:0]  csr_wdata
);

   logic [bdti_pkg::COUNT_W-1:0]   leaf_count_ff;
   logic [bdti_pkg::COUNT_W-1:0]   leaf_count_in;
   bdti_pkg::tree_cmd_type         tree_cmd;
   bdti_pkg::node_type             node_rd;
   logic [bdti_pkg::VALUE_W-1:0]   leaf_rd;
   bdti_pkg::sample_cmd_type       sample_cmd;
   logic [bdti_pkg::BIN_BITS-1:0]  bin_rd;

   assign leaf_count_in = csr_we ? csr_wdata : leaf_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= bdti_pkg::COUNT_W'(1);
      end else begin
         leaf_count_ff <= leaf_count_in;
      end
   end

   bdti_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .leaf_count (leaf_count_ff),
      .tree_cmd   (tree_cmd),
      .node_rd    (node_rd),
      .leaf_rd    (leaf_rd),
      .sample_cmd (sample_cmd),
      .bin_rd     (bin_rd)
   );

   bdti_tree_mem u_tree_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tree_cmd),
      .node_rd (node_rd),
      .leaf_rd (leaf_rd)
   );

   bdti_sample_mem u_sample_mem (
      .clock  (clock),
      .cmd    (sample_cmd),
      .bin_rd (bin_rd)
   );

endmodule

// ===== hdl/bdti_checker.sv =====
// Port-level checks of the binned decision tree inference block, bound to the top.
// Depends on bdti_pkg and binned_decision_tree_inference.
module bdti_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_op,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bdti_pkg::CHILD_W-1:0]  rsp_leaf_number,
   input logic [bdti_pkg::VALUE_W-1:0]  rsp_prediction,
   input logic                          rsp_leaf_reached
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_leaf_number) && $stable(rsp_prediction) && $stable(rsp_leaf_reached))
      else $error("stalled response changed");

   a_predict_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == bdti_pkg::OP_PREDICT) |=> !req_ready)
      else $error("request taken during a walk");

   a_miss_leaf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_leaf_reached |-> (rsp_leaf_number == '0))
      else $error("missed walk reports a nonzero leaf");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind binned_decision_tree_inference bdti_checker u_bdti_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_op           (req_if.op),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_leaf_number  (rsp_if.leaf_number),
   .rsp_prediction   (rsp_if.prediction),
   .rsp_leaf_reached (rsp_if.leaf_reached)
);
